>>> src/erp_pkg.sv
// Package for the relocation patcher: kind codes, status codes, record kinds.
// No dependencies.
package erp_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_UNSUPP   = 3'd2,
        ST_BOUNDS   = 3'd3,
        ST_SKIPPED  = 3'd4,
        ST_NORELAX  = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        K_X64_64       = 5'd0,
        K_X64_PC32     = 5'd1,
        K_X64_PLT32    = 5'd2,
        K_X64_32       = 5'd3,
        K_X64_32S      = 5'd4,
        K_X64_PC64     = 5'd5,
        K_X64_GOTPC    = 5'd6,
        K_X64_GOTPCX   = 5'd7,
        K_X64_RGOTPCX  = 5'd8,
        K_A64_ABS64    = 5'd9,
        K_A64_ABS32    = 5'd10,
        K_A64_PREL32   = 5'd11,
        K_A64_PREL64   = 5'd12,
        K_A64_CALL26   = 5'd13,
        K_A64_JUMP26   = 5'd14,
        K_A64_PG_HI21  = 5'd15,
        K_A64_GOT_PAGE = 5'd16,
        K_A64_ADD_LO12 = 5'd17,
        K_A64_LDST8    = 5'd18,
        K_A64_LDST16   = 5'd19,
        K_A64_LDST32   = 5'd20,
        K_A64_LDST64   = 5'd21,
        K_A64_LDST128  = 5'd22,
        K_A64_GOT_LO12 = 5'd23
    } kind_t;

    localparam logic [2:0] DK_X86_REL   = 3'd0;
    localparam logic [2:0] DK_X86_32    = 3'd1;
    localparam logic [2:0] DK_X86_32S   = 3'd2;
    localparam logic [2:0] DK_ARM_REL   = 3'd3;
    localparam logic [2:0] DK_ARM_ABS32 = 3'd4;

    localparam logic [1:0] WS_NONE = 2'd0;
    localparam logic [1:0] WS_FOUR = 2'd1;
    localparam logic [1:0] WS_EIGHT = 2'd2;

    localparam logic [2:0] REG_TEXT_BASE   = 3'd0;
    localparam logic [2:0] REG_RODATA_BASE = 3'd1;
    localparam logic [2:0] REG_DATA_BASE   = 3'd2;
    localparam logic [2:0] REG_TEXT_SIZE   = 3'd3;
    localparam logic [2:0] REG_RODATA_SIZE = 3'd4;
    localparam logic [2:0] REG_DATA_SIZE   = 3'd5;

    localparam logic [1:0] SEG_SKIP = 2'd0;
    localparam logic [1:0] SEG_CODE = 2'd1;
    localparam logic [1:0] SEG_RO   = 2'd2;
    localparam logic [1:0] SEG_RW   = 2'd3;

    localparam logic [7:0] OPC_MOV = 8'h8b;
    localparam logic [7:0] OPC_LEA = 8'h8d;

    // Word carried from stage 1 to stage 2
    typedef struct packed {
        logic        vld;
        logic [1:0]  sec;
        logic        oob;
        logic [31:0] off;
        logic [4:0]  kind;
        logic [63:0] place;
        logic [63:0] sa;
        logic [31:0] insn;
        logic [7:0]  opc;
    } s1_t;

    // Word carried from stage 2 to the output stage
    typedef struct packed {
        logic        vld;
        logic [1:0]  sec;
        logic        oob;
        logic        off_ge2;
        logic [4:0]  kind;
        logic [63:0] place;
        logic [63:0] sa;
        logic [63:0] pc;
        logic [63:0] pgd;
        logic [31:0] insn;
        logic [7:0]  opc;
    } s2_t;

endpackage

>>> src/elf_relocation_patcher.sv
// ELF relocation patcher top level: configuration registers and three stages.
// Depends on erp_pkg, erp_addr, erp_diff, erp_patch.
//
// One relocation is taken in every cycle (busy is always low). Its result is
// on the ports, marked by done for one cycle, once it has passed the three
// register stages: address and S+A, then S+A-P and page delta, then per-kind
// patching; the receiver cannot stall. The user must write configuration
// through cfg_valid/cfg_ready (always ready) only while idle; the block
// itself does not enforce this.
module elf_relocation_patcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  out_section,
    input  logic [31:0] patch_offset,
    input  logic [4:0]  reloc_kind,
    input  logic [63:0] symbol_value,
    input  logic signed [63:0] addend,
    input  logic [63:0] old_word,
    input  logic [7:0]  opcode_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [1:0]  write_size,
    output logic [63:0] new_word,
    output logic        opcode_write,
    output logic [7:0]  new_opcode_byte,
    output logic        dyn_valid,
    output logic [2:0]  dyn_kind,
    output logic [63:0] dyn_place,
    output logic signed [63:0] dyn_addend
);
    import erp_pkg::*;

    logic [63:0] text_base_reg, rodata_base_reg, data_base_reg;
    logic [31:0] text_size_reg, rodata_size_reg, data_size_reg;
    s1_t         s1;
    s2_t         s2;
    logic [63:0] dyn_add_u;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_base_reg   <= '0;
            rodata_base_reg <= '0;
            data_base_reg   <= '0;
            text_size_reg   <= '0;
            rodata_size_reg <= '0;
            data_size_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEXT_BASE:   text_base_reg   <= cfg_data;
                REG_RODATA_BASE: rodata_base_reg <= cfg_data;
                REG_DATA_BASE:   data_base_reg   <= cfg_data;
                REG_TEXT_SIZE:   text_size_reg   <= cfg_data[31:0];
                REG_RODATA_SIZE: rodata_size_reg <= cfg_data[31:0];
                REG_DATA_SIZE:   data_size_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    erp_addr u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (start),
        .out_section  (out_section),
        .patch_offset (patch_offset),
        .reloc_kind   (reloc_kind),
        .symbol_value (symbol_value),
        .addend       (addend),
        .old_lo       (old_word[31:0]),
        .opcode_byte  (opcode_byte),
        .text_base    (text_base_reg),
        .rodata_base  (rodata_base_reg),
        .data_base    (data_base_reg),
        .text_size    (text_size_reg),
        .rodata_size  (rodata_size_reg),
        .data_size    (data_size_reg),
        .s1           (s1)
    );

    erp_diff u_diff (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    erp_patch u_patch (
        .clk             (clk),
        .rst_n           (rst_n),
        .s2              (s2),
        .done            (done),
        .status          (status),
        .write_size      (write_size),
        .new_word        (new_word),
        .opcode_write    (opcode_write),
        .new_opcode_byte (new_opcode_byte),
        .dyn_valid       (dyn_valid),
        .dyn_kind        (dyn_kind),
        .dyn_place       (dyn_place),
        .dyn_addend      (dyn_add_u)
    );

    assign dyn_addend = dyn_add_u;

endmodule

>>> src/erp_addr.sv
// Stage 1: section select, bounds check, place address and S+A.
// Depends on erp_pkg.
module erp_addr (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [1:0]        out_section,
    input  logic [31:0]       patch_offset,
    input  logic [4:0]        reloc_kind,
    input  logic [63:0]       symbol_value,
    input  logic [63:0]       addend,
    input  logic [31:0]       old_lo,
    input  logic [7:0]        opcode_byte,
    input  logic [63:0]       text_base,
    input  logic [63:0]       rodata_base,
    input  logic [63:0]       data_base,
    input  logic [31:0]       text_size,
    input  logic [31:0]       rodata_size,
    input  logic [31:0]       data_size,
    output erp_pkg::s1_t      s1
);
    import erp_pkg::*;

    logic        vld_reg;
    s1_t         pay_reg;
    s1_t         pay_next;
    logic [63:0] base;
    logic [31:0] size;

    // section select
    always_comb
    begin
        case (out_section)
            SEG_CODE:   begin base = text_base;   size = text_size;   end
            SEG_RO:     begin base = rodata_base; size = rodata_size; end
            default:    begin base = data_base;   size = data_size;   end
        endcase
        pay_next       = '0;
        pay_next.vld   = 1'b1;
        pay_next.sec   = out_section;
        pay_next.oob   = (patch_offset >= size);
        pay_next.off   = patch_offset;
        pay_next.kind  = reloc_kind;
        pay_next.place = base + {32'd0, patch_offset};
        pay_next.sa    = symbol_value + addend;
        pay_next.insn  = old_lo;
        pay_next.opc   = opcode_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
    end

    always_comb
    begin
        s1     = pay_reg;
        s1.vld = vld_reg;
    end

endmodule

>>> src/erp_diff.sv
// Stage 2: S+A-P and page delta.
// Depends on erp_pkg.
module erp_diff (
    input  logic         clk,
    input  logic         rst_n,
    input  erp_pkg::s1_t s1,
    output erp_pkg::s2_t s2
);
    import erp_pkg::*;

    logic vld_reg;
    s2_t  pay_reg;
    s2_t  pay_next;

    always_comb
    begin
        pay_next         = '0;
        pay_next.sec     = s1.sec;
        pay_next.oob     = s1.oob;
        pay_next.off_ge2 = (s1.off >= 32'd2);
        pay_next.kind    = s1.kind;
        pay_next.place   = s1.place;
        pay_next.sa      = s1.sa;
        pay_next.pc      = s1.sa - s1.place;
        pay_next.pgd     = {s1.sa[63:12] - s1.place[63:12], 12'd0};
        pay_next.insn    = s1.insn;
        pay_next.opc     = s1.opc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= s1.vld;
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
    end

    always_comb
    begin
        s2     = pay_reg;
        s2.vld = vld_reg;
    end

endmodule

>>> src/erp_patch.sv
// Stage 3: per-kind patching, range checks, status and runtime record.
// Depends on erp_pkg.
module erp_patch (
    input  logic         clk,
    input  logic         rst_n,
    input  erp_pkg::s2_t s2,
    output logic         done,
    output logic [2:0]   status,
    output logic [1:0]   write_size,
    output logic [63:0]  new_word,
    output logic         opcode_write,
    output logic [7:0]   new_opcode_byte,
    output logic         dyn_valid,
    output logic [2:0]   dyn_kind,
    output logic [63:0]  dyn_place,
    output logic [63:0]  dyn_addend
);
    import erp_pkg::*;

    logic        done_reg;
    logic [2:0]  st_reg, st_next;
    logic [1:0]  ws_reg, ws_next;
    logic [63:0] wd_reg, wd_next;
    logic        ow_reg, ow_next;
    logic [7:0]  no_reg, no_next;
    logic        dv_reg, dv_next;
    logic [2:0]  dk_reg, dk_next;
    logic [63:0] dp_reg, dp_next;
    logic [63:0] da_reg, da_next;

    logic        ovf;
    logic        pc_s32, sa_s32, sa_u32, call_ok, page_ok;
    logic [63:0] imm;
    logic [31:0] lo12_base;
    logic [11:0] lo;
    logic [3:0]  sh;

    // range checks on the wrapped values
    assign pc_s32  = (s2.pc[63:31] == '0) || (s2.pc[63:31] == '1);
    assign sa_s32  = (s2.sa[63:31] == '0) || (s2.sa[63:31] == '1);
    assign sa_u32  = (s2.sa[63:32] == '0);
    assign call_ok = (s2.pc[63:27] == '0) || (s2.pc[63:27] == '1);
    assign imm     = {{12{s2.pgd[63]}}, s2.pgd[63:12]};
    assign page_ok = (imm[63:20] == '0) || (imm[63:20] == '1);

    always_comb
    begin
        st_next = ST_OK;
        ws_next = WS_NONE;
        wd_next = '0;
        ow_next = 1'b0;
        no_next = '0;
        dv_next = 1'b0;
        dk_next = '0;
        dp_next = '0;
        da_next = '0;
        ovf     = 1'b0;
        sh      = 4'd0;
        lo12_base = s2.insn;
        lo      = '0;
        if (s2.sec == SEG_SKIP)
            st_next = ST_SKIPPED;
        else if (s2.oob)
            st_next = ST_BOUNDS;
        else if (s2.kind > K_A64_GOT_LO12)
            st_next = ST_UNSUPP;
        else
        begin
            case (s2.kind)
                K_X64_64, K_A64_ABS64:
                begin
                    ws_next = WS_EIGHT; wd_next = s2.sa;
                    dv_next = 1'b1;
                    dk_next = (s2.kind == K_X64_64) ? DK_X86_REL : DK_ARM_REL;
                    dp_next = s2.place; da_next = s2.sa;
                end
                K_X64_PC32, K_X64_PLT32, K_A64_PREL32:
                begin
                    ws_next = WS_FOUR; wd_next = {32'd0, s2.pc[31:0]}; ovf = !pc_s32;
                end
                K_X64_32:
                begin
                    ws_next = WS_FOUR; wd_next = {32'd0, s2.sa[31:0]}; ovf = !sa_u32;
                    dv_next = 1'b1; dk_next = DK_X86_32;
                    dp_next = s2.place; da_next = s2.sa;
                end
                K_X64_32S:
                begin
                    ws_next = WS_FOUR; wd_next = {32'd0, s2.sa[31:0]}; ovf = !sa_s32;
                    dv_next = 1'b1; dk_next = DK_X86_32S;
                    dp_next = s2.place; da_next = s2.sa;
                end
                K_X64_PC64, K_A64_PREL64:
                begin
                    ws_next = WS_EIGHT; wd_next = s2.pc;
                end
                K_X64_GOTPC, K_X64_GOTPCX, K_X64_RGOTPCX:
                begin
                    ws_next = WS_FOUR; wd_next = {32'd0, s2.pc[31:0]}; ovf = !pc_s32;
                    if (s2.off_ge2 && s2.opc == OPC_MOV)
                    begin
                        ow_next = 1'b1; no_next = OPC_LEA;
                    end
                    else if (s2.off_ge2 && s2.opc != OPC_LEA)
                        st_next = ST_NORELAX;
                end
                K_A64_ABS32:
                begin
                    ws_next = WS_FOUR; wd_next = {32'd0, s2.sa[31:0]};
                    ovf = !(sa_s32 || sa_u32);
                    dv_next = 1'b1; dk_next = DK_ARM_ABS32;
                    dp_next = s2.place; da_next = s2.sa;
                end
                K_A64_CALL26, K_A64_JUMP26:
                begin
                    ovf = !call_ok; ws_next = WS_FOUR;
                    wd_next = {32'd0, (s2.insn & 32'hFC000000)
                               | (s2.pc[33:2] & 32'h03FFFFFF)};
                end
                K_A64_PG_HI21, K_A64_GOT_PAGE:
                begin
                    ovf = !page_ok; ws_next = WS_FOUR;
                    wd_next = {32'd0, (s2.insn & 32'h9F00001F)
                               | {1'b0, imm[1:0], 29'd0}
                               | {8'd0, imm[20:2] & 19'h7FFFF, 5'd0}};
                end
                default:
                begin
                    // low-12 fields; the GOT load becomes an ADD
                    case (s2.kind)
                        K_A64_LDST16:   sh = 4'd1;
                        K_A64_LDST32:   sh = 4'd2;
                        K_A64_LDST64:   sh = 4'd3;
                        K_A64_LDST128:  sh = 4'd4;
                        default:        sh = 4'd0;
                    endcase
                    if (s2.kind == K_A64_GOT_LO12)
                        lo12_base = (s2.insn & 32'h003FFFFF) | 32'h91000000;
                    lo = s2.sa[11:0] >> sh;
                    ws_next = WS_FOUR;
                    wd_next = {32'd0, (lo12_base & 32'hFFC003FF) | {10'd0, lo, 10'd0}};
                end
            endcase
            if (ovf)
                st_next = ST_OVERFLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2.vld;
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        ws_reg <= ws_next;
        wd_reg <= wd_next;
        ow_reg <= ow_next;
        no_reg <= no_next;
        dv_reg <= dv_next;
        dk_reg <= dk_next;
        dp_reg <= dp_next;
        da_reg <= da_next;
    end

    assign done            = done_reg;
    assign status          = st_reg;
    assign write_size      = ws_reg;
    assign new_word        = wd_reg;
    assign opcode_write    = ow_reg;
    assign new_opcode_byte = no_reg;
    assign dyn_valid       = dv_reg;
    assign dyn_kind        = dk_reg;
    assign dyn_place       = dp_reg;
    assign dyn_addend      = da_reg;

endmodule

>>> dv/elf_relocation_patcher_tb.sv
// Self-checking testbench for elf_relocation_patcher: drives relocation words,
// predicts each patch result and checks it. Depends on erp_pkg and the RTL.
`timescale 1ns / 1ps

module elf_relocation_patcher_tb;
    import erp_pkg::*;

    // Expected patch result, one per accepted relocation
    typedef struct {
        logic [2:0]  status;
        logic [1:0]  write_size;
        logic [63:0] new_word;
        logic        opcode_write;
        logic [7:0]  new_opcode_byte;
        logic        dyn_valid;
        logic [2:0]  dyn_kind;
        logic [63:0] dyn_place;
        logic [63:0] dyn_addend;
    } patch_t;

    // Scoreboard: queue of expected patches, in-order check
    class patch_scoreboard;
        patch_t pending_q[$];
        int     errors = 0;

        function void note_input(patch_t p);
            pending_q.push_back(p);
        endfunction

        function void check_result(patch_t got);
            patch_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, got.status);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.write_size !== e.write_size) begin
                $display("%0t: write_size exp %0d got %0d", $time, e.write_size,
                         got.write_size);
                errors++;
            end
            if (got.new_word !== e.new_word) begin
                $display("%0t: new_word exp %h got %h", $time, e.new_word, got.new_word);
                errors++;
            end
            if (got.opcode_write !== e.opcode_write) begin
                $display("%0t: opcode_write exp %0d got %0d", $time, e.opcode_write,
                         got.opcode_write);
                errors++;
            end
            if (got.new_opcode_byte !== e.new_opcode_byte) begin
                $display("%0t: new_opcode_byte exp %h got %h", $time, e.new_opcode_byte,
                         got.new_opcode_byte);
                errors++;
            end
            if (got.dyn_valid !== e.dyn_valid) begin
                $display("%0t: dyn_valid exp %0d got %0d", $time, e.dyn_valid,
                         got.dyn_valid);
                errors++;
            end
            if (got.dyn_kind !== e.dyn_kind) begin
                $display("%0t: dyn_kind exp %0d got %0d", $time, e.dyn_kind, got.dyn_kind);
                errors++;
            end
            if (got.dyn_place !== e.dyn_place) begin
                $display("%0t: dyn_place exp %h got %h", $time, e.dyn_place,
                         got.dyn_place);
                errors++;
            end
            if (got.dyn_addend !== e.dyn_addend) begin
                $display("%0t: dyn_addend exp %h got %h", $time, e.dyn_addend,
                         got.dyn_addend);
                errors++;
            end
        endfunction
    endclass

    localparam int IdleLimit = 20000;
    localparam logic [63:0] M32 = 64'hFFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  out_section = '0;
    logic [31:0] patch_offset = '0;
    logic [4:0]  reloc_kind = '0;
    logic [63:0] symbol_value = '0;
    logic signed [63:0] addend = '0;
    logic [63:0] old_word = '0;
    logic [7:0]  opcode_byte = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        done;
    logic [2:0]  status;
    logic [1:0]  write_size;
    logic [63:0] new_word;
    logic        opcode_write;
    logic [7:0]  new_opcode_byte;
    logic        dyn_valid;
    logic [2:0]  dyn_kind;
    logic [63:0] dyn_place;
    logic signed [63:0] dyn_addend;

    // Shadow copy of the section registers
    logic [63:0] sh_text_base = '0, sh_rodata_base = '0, sh_data_base = '0;
    logic [31:0] sh_text_size = '0, sh_rodata_size = '0, sh_data_size = '0;

    patch_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;

    elf_relocation_patcher dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Signed 32-bit range on a wrapped 64-bit value
    function automatic bit fits_s32(logic [63:0] v);
        logic [63:0] t;
        t = v + 64'h8000_0000;
        return t <= M32;
    endfunction

    function automatic logic [31:0] put_lo12(logic [31:0] insn, logic [63:0] sa, int sh);
        logic [31:0] lo;
        lo = 32'((sa & 64'hFFF) >> sh);
        return (insn & 32'hFFC003FF) | (lo << 10);
    endfunction

    function automatic logic [63:0] section_base(logic [1:0] sec);
        case (sec)
            SEG_CODE:   return sh_text_base;
            SEG_RO:     return sh_rodata_base;
            default:    return sh_data_base;
        endcase
    endfunction

    function automatic logic [31:0] section_size(logic [1:0] sec);
        case (sec)
            SEG_CODE:   return sh_text_size;
            SEG_RO:     return sh_rodata_size;
            default:    return sh_data_size;
        endcase
    endfunction

    // Predict the patch for one relocation under the current registers
    function automatic patch_t predict_patch(logic [1:0] sec, logic [31:0] off,
                                             logic [4:0] kind, logic [63:0] s,
                                             logic [63:0] a, logic [63:0] old,
                                             logic [7:0] opc);
        patch_t      p;
        logic [63:0] place, sa, pc, pgd, imm;
        logic [31:0] insn;
        bit          ovf;
        p = '{default: '0};
        ovf = 1'b0;
        insn = old[31:0];
        place = section_base(sec) + 64'(off);
        sa = s + a;
        pc = sa - place;
        if (sec == SEG_SKIP)
            p.status = ST_SKIPPED;
        else if (off >= section_size(sec))
            p.status = ST_BOUNDS;
        else if (kind > K_A64_GOT_LO12)
            p.status = ST_UNSUPP;
        else begin
            p.write_size = WS_FOUR;
            case (kind_t'(kind))
                K_X64_64, K_A64_ABS64:
                begin
                    p.write_size = WS_EIGHT;
                    p.new_word = sa;
                    p.dyn_valid = 1'b1;
                    p.dyn_kind = (kind == K_X64_64) ? DK_X86_REL : DK_ARM_REL;
                    p.dyn_place = place;
                    p.dyn_addend = sa;
                end
                K_X64_PC32, K_X64_PLT32, K_A64_PREL32:
                begin
                    p.new_word = pc & M32;
                    ovf = !fits_s32(pc);
                end
                K_X64_32, K_X64_32S, K_A64_ABS32:
                begin
                    p.new_word = sa & M32;
                    if (kind == K_X64_32) ovf = sa > M32;
                    else if (kind == K_X64_32S) ovf = !fits_s32(sa);
                    else ovf = !(fits_s32(sa) || sa <= M32);
                    p.dyn_valid = 1'b1;
                    p.dyn_kind = (kind == K_X64_32) ? DK_X86_32 :
                                 (kind == K_X64_32S) ? DK_X86_32S : DK_ARM_ABS32;
                    p.dyn_place = place;
                    p.dyn_addend = sa;
                end
                K_X64_PC64, K_A64_PREL64:
                begin
                    p.write_size = WS_EIGHT;
                    p.new_word = pc;
                end
                K_X64_GOTPC, K_X64_GOTPCX, K_X64_RGOTPCX:
                begin
                    p.new_word = pc & M32;
                    ovf = !fits_s32(pc);
                    if (off >= 2 && opc == OPC_MOV) begin
                        p.opcode_write = 1'b1;
                        p.new_opcode_byte = OPC_LEA;
                    end else if (off >= 2 && opc != OPC_LEA)
                        p.status = ST_NORELAX;
                end
                K_A64_CALL26, K_A64_JUMP26:
                begin
                    ovf = (pc + 64'd134217728) > 64'd268435455;
                    p.new_word = 64'((insn & 32'hFC000000) | (32'(pc >> 2) & 32'h03FFFFFF));
                end
                K_A64_PG_HI21, K_A64_GOT_PAGE:
                begin
                    pgd = (sa & ~64'hFFF) - (place & ~64'hFFF);
                    imm = $signed(pgd) >>> 12;
                    ovf = (imm + 64'd1048576) > 64'd2097151;
                    p.new_word = 64'((insn & 32'h9F00001F) | ((32'(imm) & 32'd3) << 29)
                                     | ((32'(imm >> 2) & 32'h7FFFF) << 5));
                end
                K_A64_ADD_LO12, K_A64_LDST8: p.new_word = 64'(put_lo12(insn, sa, 0));
                K_A64_LDST16:  p.new_word = 64'(put_lo12(insn, sa, 1));
                K_A64_LDST32:  p.new_word = 64'(put_lo12(insn, sa, 2));
                K_A64_LDST64:  p.new_word = 64'(put_lo12(insn, sa, 3));
                K_A64_LDST128: p.new_word = 64'(put_lo12(insn, sa, 4));
                default:
                    p.new_word = 64'(put_lo12((insn & 32'h003FFFFF) | 32'h91000000, sa, 0));
            endcase
            if (ovf)
                p.status = ST_OVERFLOW;
        end
        return p;
    endfunction

    // Result monitor
    always @(posedge clk)
    begin
        patch_t got;
        if (done) begin
            got.status = status;
            got.write_size = write_size;
            got.new_word = new_word;
            got.opcode_write = opcode_write;
            got.new_opcode_byte = new_opcode_byte;
            got.dyn_valid = dyn_valid;
            got.dyn_kind = dyn_kind;
            got.dyn_place = dyn_place;
            got.dyn_addend = dyn_addend;
            sb.check_result(got);
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (done || (start && !busy) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else if (rst_n && ++idle_cycles >= IdleLimit) begin
            $display("elf_relocation_patcher test failed");
            $finish;
        end
    end

    // Register write on the configuration channel; updates the shadow copy
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TEXT_BASE:   sh_text_base = data;
            REG_RODATA_BASE: sh_rodata_base = data;
            REG_DATA_BASE:   sh_data_base = data;
            REG_TEXT_SIZE:   sh_text_size = data[31:0];
            REG_RODATA_SIZE: sh_rodata_size = data[31:0];
            default:         sh_data_size = data[31:0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending_q.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One relocation word; start stays high into the next word of a burst
    task automatic send_reloc(logic [1:0] sec, logic [31:0] off, logic [4:0] kind,
                              logic [63:0] s, logic [63:0] a, logic [63:0] old,
                              logic [7:0] opc);
        @(negedge clk);
        start = 1'b1;
        out_section = sec;
        patch_offset = off;
        reloc_kind = kind;
        symbol_value = s;
        addend = a;
        old_word = old;
        opcode_byte = opc;
        do @(posedge clk); while (busy);
        sb.note_input(predict_patch(sec, off, kind, s, a, old, opc));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random relocation, mostly in bounds with S+A near P so ranges hold
    task automatic send_random(bit gaps);
        logic [1:0]  sec;
        logic [31:0] off, sz;
        logic [4:0]  kind;
        logic [63:0] a, s, delta;
        logic [7:0]  opc;
        int          r;
        if (gaps && burst_left == 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        sec = ($urandom_range(0, 15) == 0) ? SEG_SKIP : 2'($urandom_range(1, 3));
        sz = section_size(sec);
        r = $urandom_range(0, 9);
        if (r == 0) off = $urandom;
        else if (r == 1) off = $urandom_range(0, 1);
        else if (r == 2 && sz != 0) off = sz - 1;
        else if (sz != 0) off = $urandom % (sz < 32'h10000 ? sz : 32'h10000);
        else off = $urandom;
        kind = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
        a = rand64();
        r = $urandom_range(0, 5);
        if (r == 0) delta = rand64();
        else if (r == 1) delta = 64'($signed(32'($urandom)));
        else if (r == 2) delta = {{32{1'b0}}, $urandom};
        else if (r == 3) delta = 64'($signed(29'($urandom)));
        else delta = 64'($signed(22'($urandom)));
        s = ($urandom_range(0, 7) == 0) ? rand64() : section_base(sec) + 64'(off) + delta - a;
        r = $urandom_range(0, 2);
        opc = (r == 0) ? OPC_MOV : (r == 1) ? OPC_LEA : 8'($urandom);
        send_reloc(sec, off, kind, s, a, rand64(), opc);
    endtask

    task automatic set_sizes(logic [63:0] t, logic [63:0] r, logic [63:0] d);
        write_reg(REG_TEXT_SIZE, t);
        write_reg(REG_RODATA_SIZE, r);
        write_reg(REG_DATA_SIZE, d);
    endtask

    task automatic set_bases(logic [63:0] t, logic [63:0] r, logic [63:0] d);
        write_reg(REG_TEXT_BASE, t);
        write_reg(REG_RODATA_BASE, r);
        write_reg(REG_DATA_BASE, d);
    endtask

    initial
    begin
        logic [63:0] sbase;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every kind in range, then the special cases
        set_bases(64'h0000_0000_0040_1000, rand64(), rand64());
        set_sizes(64'hFFFF_FFFF_0000_0100, 64'hFFFF_FFFF, 64'h10);
        for (int k = 0; k <= K_A64_GOT_LO12; k++)
            send_reloc(SEG_CODE, 32'h40, 5'(k), 64'h0000_0000_0040_2345, 64'sd8,
                       rand64(), OPC_MOV);
        send_reloc(SEG_SKIP, 32'h0, K_X64_64, rand64(), rand64(), rand64(), OPC_MOV);
        send_reloc(SEG_RW, 32'h10, K_X64_64, rand64(), rand64(), rand64(), 8'h0);
        send_reloc(SEG_CODE, 32'h8, 5'd31, rand64(), rand64(), rand64(), 8'hFF);
        send_reloc(SEG_CODE, 32'h8, K_X64_GOTPCX, 64'h0040_1000, 64'h0, 64'h0, 8'h55);
        send_reloc(SEG_CODE, 32'h8, K_X64_RGOTPCX, 64'h0040_1000, 64'h0, '1, OPC_LEA);
        send_reloc(SEG_CODE, 32'h1, K_X64_GOTPC, 64'h0040_1000, 64'h0, '0, 8'h55);
        send_reloc(SEG_CODE, 32'hFF, K_A64_ABS32, 64'hFFFF_FFFF, 64'h0, '1, 8'h0);
        send_reloc(SEG_CODE, 32'h0, K_A64_ABS32, 64'hFFFF_FFFF_8000_0000, 64'h0, '0, 8'h0);
        send_reloc(SEG_CODE, 32'h0, K_X64_32S, '1, '1, '1, 8'hFF);
        @(negedge clk);
        start = 1'b0;
        wait_idle();

        // Random phases over a range of register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin set_bases('0, '0, '0); set_sizes('1, '1, '1); end
                1: begin set_bases('1, '1, '1); set_sizes(64'h40, 64'h1, '1); end
                2: begin set_bases(rand64(), rand64(), rand64()); set_sizes(rand64(),
                         rand64(), rand64()); end
                3: begin set_bases(64'h7FFF_FFFF_FFFF_F000, 64'h8000_0000_0000_0000,
                         64'hFFFF_FFFF_8000_0000); set_sizes('0, 64'h1000, 64'h3); end
                default: begin
                    sbase = rand64();
                    set_bases(sbase, sbase + 64'h10_0000, sbase - 64'h10_0000);
                    set_sizes(64'(32'($urandom_range(1, 4096))), rand64(), 64'h2_0000);
                end
            endcase
            for (int i = 0; i < 285; i++)
                send_random(ph != 2);
            @(negedge clk);
            start = 1'b0;
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("elf_relocation_patcher test passed");
        else
            $display("elf_relocation_patcher test failed");
        $finish;
    end

endmodule

>>> elf_relocation_patcher.f
src/erp_pkg.sv
src/erp_addr.sv
src/erp_diff.sv
src/erp_patch.sv
src/elf_relocation_patcher.sv
dv/elf_relocation_patcher_tb.sv
